### src/buvs_pkg.sv
package buvs_pkg;

  localparam int MAX_BOXES  = 4096;
  localparam int COORD_BITS = 21;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int LEN_W      = COORD_BITS + 1;
  localparam int VOL_W      = 64;
  localparam int COUNT_OUT_W = 13;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_INV  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam coord_t ONE = coord_t'(1);

  typedef struct packed {
    coord_t xl;
    coord_t xh;
    coord_t yl;
    coord_t yh;
    coord_t zl;
    coord_t zh;
  } box_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;
    logic       rd_en;
    logic       latch;
    logic       emit;
    logic       append;
    logic       finish;
    logic [1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic inverted;
    logic more_src;
    logic full;
    logic mask_empty;
    logic mask_last;
    logic turn_on;
    logic vol_idle;
  } sts_t;

  function automatic len_t span_len(coord_t lo, coord_t hi);
    logic [COORD_BITS:0] d;
    d = {hi[COORD_BITS-1], hi} - {lo[COORD_BITS-1], lo};
    return len_t'(d) + len_t'(1);
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

### src/box_union_volume_by_subtraction_core.sv
// Each item walks the stored boxes: read one, latch it, and write its pieces into
// the other bank, then append the new box and drain the volume multiplier pipeline;
// the walk is set by the single-port access to the box memory.
// Throughput: one item at a time; a new item is taken once the previous one's result
// sits in the output register. Reset (rst, synchronous) empties the box list, zeroes
// the volume and selects bank zero; the box memory itself is not cleared.
module box_union_volume_by_subtraction_core
  import buvs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   turn_on,
  input  coord_t                 x_low,
  input  coord_t                 x_high,
  input  coord_t                 y_low,
  input  coord_t                 y_high,
  input  coord_t                 z_low,
  input  coord_t                 z_high,
  input  logic                   last_box,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VOL_W-1:0]       lit_volume,
  output logic [COUNT_OUT_W-1:0] stored_boxes,
  output logic [1:0]             status
);

  // The controller sequences the walk: read a stored box, latch it together with
  // its overlap pieces, write the pieces one per cycle into the other bank, and
  // finally append the new box when it is lit.
  cmd_t cmd;
  sts_t sts;

  buvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds both banks, the piece generator, the volume pipeline
  // and the committed list state.
  buvs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .turn_on      (turn_on),
    .x_low        (x_low),
    .x_high       (x_high),
    .y_low        (y_low),
    .y_high       (y_high),
    .z_low        (z_low),
    .z_high       (z_high),
    .last_box     (last_box),
    .cmd          (cmd),
    .sts          (sts),
    .lit_volume   (lit_volume),
    .stored_boxes (stored_boxes),
    .status       (status)
  );

  // A result never carries a status code outside the defined set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_INV || status == ST_FULL))
    else $error("undefined status code");

  // An applied item that leaves the list empty reports zero volume.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK && stored_boxes == '0) |-> (lit_volume == '0))
    else $error("empty list with nonzero volume");

  // A finishing item never completes while slabs are still in the volume pipeline.
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.vol_idle)
    else $error("result taken before volume pipeline drained");

endmodule

### src/buvs_ctrl.sv
module buvs_ctrl
  import buvs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_NEXT   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_LATCH  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_DRAIN  = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] status, status_next;
  logic       out_slot_free;

  assign in_ready      = (state == S_IDLE);
  assign out_slot_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    status_next = status;
    cmd         = '0;
    cmd.status  = status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start   = 1'b1;
          status_next = ST_OK;
          state_next  = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.inverted) begin
          status_next = ST_INV;
          state_next  = S_DRAIN;
        end else if (sts.more_src) begin
          state_next = S_RD;
        end else if (sts.turn_on) begin
          state_next = S_APPEND;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LATCH;
      end
      S_LATCH: begin
        cmd.latch  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.mask_empty) begin
          state_next = S_NEXT;
        end else if (sts.full) begin
          status_next = ST_FULL;
          state_next  = S_DRAIN;
        end else begin
          cmd.emit = 1'b1;
          if (sts.mask_last) begin
            state_next = S_NEXT;
          end
        end
      end
      S_APPEND: begin
        if (sts.full) begin
          status_next = ST_FULL;
        end else begin
          cmd.append = 1'b1;
        end
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.vol_idle && out_slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/buvs_datapath.sv
module buvs_datapath
  import buvs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   turn_on,
  input  coord_t                 x_low,
  input  coord_t                 x_high,
  input  coord_t                 y_low,
  input  coord_t                 y_high,
  input  coord_t                 z_low,
  input  coord_t                 z_high,
  input  logic                   last_box,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic [VOL_W-1:0]       lit_volume,
  output logic [COUNT_OUT_W-1:0] stored_boxes,
  output logic [1:0]             status
);

  box_t mem [2*MAX_BOXES];

  box_t       nbox, rbox, sbox, ibox, piece, wbox;
  logic       turn_on_r, last_r;
  logic [6:0] mask;
  logic [CNT_W-1:0] ridx, wcount, box_count;
  logic       active_bank;
  logic [VOL_W-1:0] volume, acc;
  logic       wr_en, ok;

  // Volume pipeline registers.
  logic       va_v, vb_v, vc_v, vd_v;
  len_t       lx, ly, lz, lz_b;
  logic [2*LEN_W-1:0] pxy, plo, phi;
  logic [VOL_W-1:0]   vbox;

  assign wr_en = cmd.emit || cmd.append;
  assign ok    = (cmd.status == ST_OK);

  // Select the lowest pending piece of the latched stored box.
  always_comb begin
    piece = sbox;
    if (mask[0]) begin
      piece.xh = ibox.xl - ONE;
      piece.zl = ibox.zl;
      piece.zh = ibox.zh;
    end else if (mask[1]) begin
      piece.xl = ibox.xh + ONE;
      piece.zl = ibox.zl;
      piece.zh = ibox.zh;
    end else if (mask[2]) begin
      piece.xl = ibox.xl;
      piece.xh = ibox.xh;
      piece.yh = ibox.yl - ONE;
      piece.zl = ibox.zl;
      piece.zh = ibox.zh;
    end else if (mask[3]) begin
      piece.xl = ibox.xl;
      piece.xh = ibox.xh;
      piece.yl = ibox.yh + ONE;
      piece.zl = ibox.zl;
      piece.zh = ibox.zh;
    end else if (mask[4]) begin
      piece.zh = ibox.zl - ONE;
    end else if (mask[5]) begin
      piece.zl = ibox.zh + ONE;
    end
  end

  assign wbox = cmd.append ? nbox : piece;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{~active_bank, wcount[IDX_W-1:0]}] <= wbox;
    end
    if (cmd.rd_en) begin
      rbox <= mem[{active_bank, ridx[IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    box_t clipped;
    logic apart;
    clipped.xl = cmax(rbox.xl, nbox.xl);
    clipped.xh = cmin(rbox.xh, nbox.xh);
    clipped.yl = cmax(rbox.yl, nbox.yl);
    clipped.yh = cmin(rbox.yh, nbox.yh);
    clipped.zl = cmax(rbox.zl, nbox.zl);
    clipped.zh = cmin(rbox.zh, nbox.zh);
    apart = (rbox.xh < nbox.xl) || (nbox.xh < rbox.xl) ||
            (rbox.yh < nbox.yl) || (nbox.yh < rbox.yl) ||
            (rbox.zh < nbox.zl) || (nbox.zh < rbox.zl);
    if (cmd.start) begin
      nbox      <= '{xl: x_low, xh: x_high, yl: y_low, yh: y_high,
                     zl: z_low, zh: z_high};
      turn_on_r <= turn_on;
      last_r    <= last_box;
      ridx      <= '0;
      wcount    <= '0;
    end
    if (cmd.rd_en) begin
      ridx <= ridx + CNT_W'(1);
    end
    if (wr_en) begin
      wcount <= wcount + CNT_W'(1);
    end
    if (cmd.latch) begin
      sbox <= rbox;
      ibox <= clipped;
      if (apart) begin
        mask <= 7'b1000000;
      end else begin
        mask <= {1'b0,
                 clipped.zh < rbox.zh, rbox.zl < clipped.zl,
                 clipped.yh < rbox.yh, rbox.yl < clipped.yl,
                 clipped.xh < rbox.xh, rbox.xl < clipped.xl};
      end
    end else if (cmd.emit) begin
      mask <= mask & (mask - 7'd1);
    end
  end

  // Volume of every written box, summed through a four-stage pipeline.
  always_ff @(posedge clk) begin
    lx   <= span_len(wbox.xl, wbox.xh);
    ly   <= span_len(wbox.yl, wbox.yh);
    lz   <= span_len(wbox.zl, wbox.zh);
    pxy  <= (2*LEN_W)'(lx) * (2*LEN_W)'(ly);
    lz_b <= lz;
    plo  <= (2*LEN_W)'(pxy[LEN_W-1:0]) * (2*LEN_W)'(lz_b);
    phi  <= (2*LEN_W)'(pxy[2*LEN_W-1:LEN_W]) * (2*LEN_W)'(lz_b);
    vbox <= VOL_W'(plo) + (VOL_W'(phi) << LEN_W);
    if (cmd.start) begin
      acc <= '0;
    end else if (vd_v) begin
      acc <= acc + vbox;
    end
    if (rst) begin
      va_v <= 1'b0;
      vb_v <= 1'b0;
      vc_v <= 1'b0;
      vd_v <= 1'b0;
    end else begin
      va_v <= wr_en;
      vb_v <= va_v;
      vc_v <= vb_v;
      vd_v <= vc_v;
    end
  end

  // Committed list state and the result register.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      lit_volume   <= ok ? acc : volume;
      stored_boxes <= COUNT_OUT_W'(ok ? wcount : box_count);
      status       <= cmd.status;
    end
    if (rst) begin
      box_count   <= '0;
      active_bank <= 1'b0;
      volume      <= '0;
    end else if (cmd.finish) begin
      if (ok) begin
        active_bank <= ~active_bank;
      end
      if (last_r) begin
        box_count <= '0;
        volume    <= '0;
      end else if (ok) begin
        box_count <= wcount;
        volume    <= acc;
      end
    end
  end

  assign sts.inverted   = (nbox.xl > nbox.xh) || (nbox.yl > nbox.yh) ||
                          (nbox.zl > nbox.zh);
  assign sts.more_src   = (ridx < box_count);
  assign sts.full       = (wcount == CNT_W'(MAX_BOXES));
  assign sts.mask_empty = (mask == 7'd0);
  assign sts.mask_last  = ((mask & (mask - 7'd1)) == 7'd0);
  assign sts.turn_on    = turn_on_r;
  assign sts.vol_idle   = !(va_v || vb_v || vc_v || vd_v);

endmodule

### test/box_union_volume_by_subtraction_core_tb.sv
`timescale 1ns / 100ps

module box_union_volume_by_subtraction_core_tb;
  import buvs_pkg::*;

  // One expected result as the block should report it.
  typedef struct {
    logic [VOL_W-1:0]       vol;
    logic [COUNT_OUT_W-1:0] cnt;
    logic [1:0]             st;
  } result_t;

  // One row of the directed stimulus table.  When typed is set, the row carries a
  // result that can be read off the spec directly; otherwise the predictor decides.
  typedef struct {
    logic    on;
    box_t    b;
    logic    last;
    logic    typed;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   turn_on = 1'b0;
  coord_t                 x_low = '0;
  coord_t                 x_high = '0;
  coord_t                 y_low = '0;
  coord_t                 y_high = '0;
  coord_t                 z_low = '0;
  coord_t                 z_high = '0;
  logic                   last_box = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [VOL_W-1:0]       lit_volume;
  logic [COUNT_OUT_W-1:0] stored_boxes;
  logic [1:0]             status;

  box_union_volume_by_subtraction_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .turn_on(turn_on),
    .x_low(x_low), .x_high(x_high),
    .y_low(y_low), .y_high(y_high),
    .z_low(z_low), .z_high(z_high),
    .last_box(last_box),
    .out_valid(out_valid), .out_ready(out_ready),
    .lit_volume(lit_volume), .stored_boxes(stored_boxes), .status(status)
  );

  always #2 clk = ~clk;

  // The predictor keeps its own two banks of disjoint boxes, exactly as the block
  // does: each applied item rebuilds the list into the other bank.
  box_t            lit_bank [2][MAX_BOXES];
  int unsigned     lit_count;
  int unsigned     build_idx;
  bit              cur_bank;
  logic [VOL_W-1:0] lit_sum;
  result_t         pending_results[$];

  int unsigned snd_idle_pct = 9;
  int unsigned rcv_idle_pct = 65;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  localparam int unsigned QUIET_LIMIT = 200000;

  function automatic logic [VOL_W-1:0] box_volume(box_t b);
    logic [VOL_W-1:0] lx, ly, lz;
    lx = VOL_W'(longint'(b.xh) - longint'(b.xl) + 1);
    ly = VOL_W'(longint'(b.yh) - longint'(b.yl) + 1);
    lz = VOL_W'(longint'(b.zh) - longint'(b.zl) + 1);
    return lx * ly * lz;
  endfunction

  task automatic store_slab(bit bank, box_t b);
    if (build_idx < MAX_BOXES) lit_bank[bank][build_idx] = b;
    build_idx++;
  endtask

  // Work out the result of one accepted item and advance the predicted state.
  task automatic predict_union(logic on, box_t nb, logic last, output result_t r);
    box_t  s, ov, t;
    bit    dst;
    logic [1:0] st;
    st = ST_OK;
    dst = ~cur_bank;
    if (nb.xl > nb.xh || nb.yl > nb.yh || nb.zl > nb.zh) begin
      st = ST_INV;
    end else begin
      build_idx = 0;
      for (int i = 0; i < lit_count; i++) begin
        s = lit_bank[cur_bank][i];
        if (s.xh < nb.xl || nb.xh < s.xl || s.yh < nb.yl || nb.yh < s.yl ||
            s.zh < nb.zl || nb.zh < s.zl) begin
          store_slab(dst, s);
        end else begin
          // The overlap, then x slabs, y slabs and z slabs of what lies outside it.
          ov.xl = (s.xl > nb.xl) ? s.xl : nb.xl;
          ov.xh = (s.xh < nb.xh) ? s.xh : nb.xh;
          ov.yl = (s.yl > nb.yl) ? s.yl : nb.yl;
          ov.yh = (s.yh < nb.yh) ? s.yh : nb.yh;
          ov.zl = (s.zl > nb.zl) ? s.zl : nb.zl;
          ov.zh = (s.zh < nb.zh) ? s.zh : nb.zh;
          t = s; t.zl = ov.zl; t.zh = ov.zh;
          if (s.xl < ov.xl) begin t.xl = s.xl; t.xh = ov.xl - ONE; store_slab(dst, t); end
          if (ov.xh < s.xh) begin t.xl = ov.xh + ONE; t.xh = s.xh; store_slab(dst, t); end
          t = ov;
          if (s.yl < ov.yl) begin t.yl = s.yl; t.yh = ov.yl - ONE; store_slab(dst, t); end
          if (ov.yh < s.yh) begin t.yl = ov.yh + ONE; t.yh = s.yh; store_slab(dst, t); end
          t = s;
          if (s.zl < ov.zl) begin t.zl = s.zl; t.zh = ov.zl - ONE; store_slab(dst, t); end
          if (ov.zh < s.zh) begin t.zl = ov.zh + ONE; t.zh = s.zh; store_slab(dst, t); end
        end
      end
      if (on) store_slab(dst, nb);
      if (build_idx > MAX_BOXES) begin
        st = ST_FULL;
      end else begin
        cur_bank = dst;
        lit_count = build_idx;
        lit_sum = '0;
        for (int i = 0; i < lit_count; i++) lit_sum += box_volume(lit_bank[dst][i]);
      end
    end
    r.vol = lit_sum;
    r.cnt = COUNT_OUT_W'(lit_count);
    r.st = st;
    if (last) begin
      lit_count = 0;
      lit_sum = '0;
    end
  endtask

  // Present one item, hold it until the transfer, then record what it should give.
  task automatic send_box(logic on, box_t b, logic last, logic typed, result_t typed_res);
    int unsigned gap;
    result_t     r;
    gap = 0;
    if ($urandom_range(99) < snd_idle_pct) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    turn_on  <= on;
    x_low <= b.xl; x_high <= b.xh;
    y_low <= b.yl; y_high <= b.yh;
    z_low <= b.zl; z_high <= b.zh;
    last_box <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_union(on, b, last, r);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  function automatic coord_t pick_coord(bit wide);
    if (wide) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 24)) - coord_t'(8);
  endfunction

  // Mostly small overlapping boxes so the cutting paths are exercised, with a few
  // wide ones so every coordinate bit toggles, and some inverted bounds as noise.
  task automatic send_random_box();
    box_t   b;
    coord_t a, c;
    bit     wide;
    result_t none;
    none = '{default: '0};
    wide = ($urandom_range(99) < 15);
    for (int k = 0; k < 3; k++) begin
      a = pick_coord(wide);
      c = pick_coord(wide);
      if (a > c) begin
        coord_t tmp;
        tmp = a; a = c; c = tmp;
      end
      if (k == 0) begin b.xl = a; b.xh = c; end
      if (k == 1) begin b.yl = a; b.yh = c; end
      if (k == 2) begin b.zl = a; b.zh = c; end
    end
    if ($urandom_range(99) < 6) begin
      b.yl = b.yh + ONE;
    end
    send_box($urandom_range(99) < 65, b, $urandom_range(99) < 8, 1'b0, none);
  endtask

  function automatic box_t mk(int xl, int xh, int yl, int yh, int zl, int zh);
    box_t b;
    b.xl = coord_t'(xl); b.xh = coord_t'(xh);
    b.yl = coord_t'(yl); b.yh = coord_t'(yh);
    b.zl = coord_t'(zl); b.zh = coord_t'(zh);
    return b;
  endfunction

  // Result check and receiver-side idling.  Outputs are sampled at the clock edge,
  // before any of this edge's updates, so the transfer seen here is the real one.
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
          $display("[box_union_volume_by_subtraction_core] ERROR");
          $finish;
        end
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result vol=%0d cnt=%0d st=%0d", $realtime,
                   lit_volume, stored_boxes, status);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (lit_volume !== e.vol) begin
            $display("%0t: lit_volume expected %0d got %0d", $realtime, e.vol, lit_volume);
            errors++;
          end
          if (stored_boxes !== e.cnt) begin
            $display("%0t: stored_boxes expected %0d got %0d", $realtime, e.cnt,
                     stored_boxes);
            errors++;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d got %0d", $realtime, e.st, status);
            errors++;
          end
        end
      end
    end
  end

  row_t table_rows[$];

  initial begin
    row_t    row;
    result_t none;
    none = '{default: '0};
    lit_count = 0;
    cur_bank = 0;
    lit_sum = '0;

    // Directed table.  Rows with a typed result follow from the spec at a glance.
    // Inverted bounds straight after reset: empty list, nothing changes.
    table_rows.push_back('{1'b1, mk(5, 4, 0, 0, 0, 0), 1'b0, 1'b1, '{0, 0, ST_INV}});
    // The whole coordinate space as one lit box: 2^21 cubed.
    table_rows.push_back('{1'b1, mk(-1048576, 1048575, -1048576, 1048575, -1048576,
                           1048575), 1'b0, 1'b1, '{64'h8000_0000_0000_0000, 1, ST_OK}});
    // Inverted bounds on y and on z leave that box alone.
    table_rows.push_back('{1'b1, mk(0, 0, 3, 2, 0, 0), 1'b0, 1'b1,
                           '{64'h8000_0000_0000_0000, 1, ST_INV}});
    table_rows.push_back('{1'b0, mk(0, 0, 0, 0, 1048575, -1048576), 1'b0, 1'b1,
                           '{64'h8000_0000_0000_0000, 1, ST_INV}});
    // Removing the whole space removes everything.
    table_rows.push_back('{1'b0, mk(-1048576, 1048575, -1048576, 1048575, -1048576,
                           1048575), 1'b0, 1'b1, '{0, 0, ST_OK}});
    // Single cells at the extreme corners.
    table_rows.push_back('{1'b1, mk(1048575, 1048575, 1048575, 1048575, 1048575,
                           1048575), 1'b0, 1'b1, '{1, 1, ST_OK}});
    table_rows.push_back('{1'b1, mk(-1048576, -1048576, -1048576, -1048576, -1048576,
                           -1048576), 1'b0, 1'b1, '{2, 2, ST_OK}});
    // Last flag: result first, then the list is emptied.
    table_rows.push_back('{1'b1, mk(0, 1, 0, 1, 0, 1), 1'b1, 1'b1, '{10, 3, ST_OK}});
    table_rows.push_back('{1'b0, mk(0, 0, 0, 0, 0, 0), 1'b0, 1'b1, '{0, 0, ST_OK}});
    // Cuts from every side: a block, then a hole in the middle, then partial overlaps.
    table_rows.push_back('{1'b1, mk(0, 9, 0, 9, 0, 9), 1'b0, 1'b1, '{1000, 1, ST_OK}});
    table_rows.push_back('{1'b0, mk(3, 5, 3, 5, 3, 5), 1'b0, 1'b0, none});
    table_rows.push_back('{1'b1, mk(-4, 2, 8, 12, 4, 4), 1'b0, 1'b0, none});
    table_rows.push_back('{1'b1, mk(4, 4, 4, 4, 4, 4), 1'b0, 1'b0, none});
    table_rows.push_back('{1'b0, mk(9, 20, -3, 0, 0, 9), 1'b0, 1'b0, none});
    table_rows.push_back('{1'b1, mk(-2, 11, -2, 11, -2, 11), 1'b0, 1'b0, none});
    // Inverted bounds with the last flag still clear the list.
    table_rows.push_back('{1'b1, mk(2, 1, 0, 0, 0, 0), 1'b1, 1'b0, none});
    table_rows.push_back('{1'b0, mk(0, 3, 0, 3, 0, 3), 1'b0, 1'b1, '{0, 0, ST_OK}});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_box(row.on, row.b, row.last, row.typed, row.res);
    end

    for (int n = 0; n < 75; n++) begin
      if (n == 25) begin
        snd_idle_pct = 65;
        rcv_idle_pct = 9;
      end
      if (n == 50) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      send_random_box();
    end

    // Let every result drain before building a full store from an empty list.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    // Store full: a lit 32-cube cut by 15 planes on each axis leaves exactly
    // 16 * 16 * 16 boxes; one more disjoint box no longer fits.
    send_box(1'b0, mk(-1048576, 1048575, -1048576, 1048575, -1048576, 1048575), 1'b1,
             1'b0, none);
    send_box(1'b1, mk(0, 31, 0, 31, 0, 31), 1'b0, 1'b0, none);
    for (int p = 1; p < 30; p += 2) send_box(1'b0, mk(p, p, 0, 31, 0, 31), 1'b0, 1'b0, none);
    for (int p = 1; p < 30; p += 2) send_box(1'b0, mk(0, 31, p, p, 0, 31), 1'b0, 1'b0, none);
    for (int p = 1; p < 30; p += 2) send_box(1'b0, mk(0, 31, 0, 31, p, p), 1'b0, 1'b0, none);
    send_box(1'b1, mk(100, 100, 100, 100, 100, 100), 1'b0, 1'b0, none);
    // An off plane that removes the 256 boxes at x zero, then clear with the last flag.
    send_box(1'b0, mk(0, 0, 0, 31, 0, 31), 1'b1, 1'b0, none);
    send_box(1'b1, mk(1, 2, 1, 2, 1, 2), 1'b1, 1'b0, none);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0) begin
      $display("[box_union_volume_by_subtraction_core] OK");
    end else begin
      $display("[box_union_volume_by_subtraction_core] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/buvs_pkg.sv
src/buvs_ctrl.sv
src/buvs_datapath.sv
src/box_union_volume_by_subtraction_core.sv
test/box_union_volume_by_subtraction_core_tb.sv
